// ----- rtl/arpc_pkg.sv -----
// Shared types and constants for the ARP address cache.
// Used by arp_address_cache and its port checker; no dependencies.
package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int IDX_W = 4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

endpackage

// ----- rtl/arp_address_cache.sv -----
// ARP address cache top level: fully associative IPv4-to-MAC table with
// round-robin replacement. Depends on arpc_pkg.
//
// Request channel (req_valid / req_stall): one beat per request with
// operation (lookup or insert), ip_address and mac_address. Response channel
// (rsp_valid / rsp_stall): exactly one beat per request with hit, mac_result
// and entry_index, in request order.
//
// IP and MAC tables sit in two synchronous RAMs (registered read). A request
// walks the RAM one entry per cycle, comparing the entry read the cycle
// before, and stops at the first valid match; an insert writes back in the
// cycle the match or miss is decided. One request is in flight; req_stall
// drops once the result is in the output register, so a new request is not
// taken before the previous one has finished.
// A result that finishes while rsp_stall holds an earlier beat is parked and
// requests wait until the output register frees up.
// Reset clears the valid flops, the pointer and both handshakes; RAMs are not
// cleared, since an entry is only compared once its valid bit is set.
module arp_address_cache
  import arpc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             operation,
  input  logic [IP_W-1:0]  ip_address,
  input  logic [MAC_W-1:0] mac_address,
  // response channel
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic             hit,
  output logic [MAC_W-1:0] mac_result,
  output logic [IDX_W-1:0] entry_index
);

  localparam int IW = $clog2(ENTRIES);

  // table storage
  logic [IP_W-1:0]  ip_mem  [ENTRIES];
  logic [MAC_W-1:0] mac_mem [ENTRIES];
  logic [IP_W-1:0]  ip_rd;
  logic [MAC_W-1:0] mac_rd;
  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]      ptr;

  // request context
  state_t           state, state_next;
  logic             key_op;
  logic [IP_W-1:0]  key_ip;
  logic [MAC_W-1:0] key_mac;

  // walk control: scan_cnt is the next address to read, cmp_idx the
  // address whose data is on ip_rd / mac_rd when rd_pend is set
  logic [IW:0]   scan_cnt;
  logic          rd_pend;
  logic [IW-1:0] cmp_idx;

  // parked result
  logic             res_hit;
  logic [MAC_W-1:0] res_mac;
  logic [IDX_W-1:0] res_idx;

  logic             req_take;
  logic             slot_free;
  logic             match;
  logic             scan_over;
  logic             finish;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic             wr_ip;
  logic [IW-1:0]    wr_addr;
  logic             fin_hit;
  logic [MAC_W-1:0] fin_mac;
  logic [IDX_W-1:0] fin_idx;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  assign match     = rd_pend && valid[cmp_idx] && (ip_rd == key_ip);
  assign scan_over = !rd_pend && (scan_cnt == (IW+1)'(ENTRIES));
  assign finish    = (state == ST_SCAN) && (match || scan_over);
  assign rd_en     = (state == ST_SCAN) && !match && (scan_cnt != (IW+1)'(ENTRIES));
  assign rd_addr   = scan_cnt[IW-1:0];

  // insert: refresh the matched MAC, or claim the round-robin slot
  assign wr_en   = finish && (key_op == OP_INSERT);
  assign wr_ip   = !match;
  assign wr_addr = match ? cmp_idx : ptr;

  always_comb begin
    fin_hit = match;
    fin_mac = '0;
    fin_idx = '0;
    if (match) begin
      fin_idx = IDX_W'(cmp_idx);
      if (key_op == OP_LOOKUP) begin
        fin_mac = mac_rd;
      end
    end else if (key_op == OP_INSERT) begin
      fin_idx = IDX_W'(ptr);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = slot_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      ptr       <= '0;
      scan_cnt  <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (req_take) begin
        scan_cnt <= '0;
      end else if (rd_en) begin
        scan_cnt <= scan_cnt + (IW+1)'(1);
      end
      rd_pend <= rd_en;

      if (wr_en && wr_ip) begin
        valid[ptr] <= 1'b1;
        ptr <= (ptr == IW'(ENTRIES-1)) ? '0 : ptr + IW'(1);
      end

      if ((finish || (state == ST_HOLD)) && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // RAMs: one read port for the walk, one write port for the write-back
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ip_rd  <= ip_mem[rd_addr];
      mac_rd <= mac_mem[rd_addr];
    end
    if (wr_en) begin
      mac_mem[wr_addr] <= key_mac;
      if (wr_ip) begin
        ip_mem[wr_addr] <= key_ip;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      key_op  <= operation;
      key_ip  <= ip_address;
      key_mac <= mac_address;
    end
    if (rd_en) begin
      cmp_idx <= rd_addr;
    end
    if (finish) begin
      res_hit <= fin_hit;
      res_mac <= fin_mac;
      res_idx <= fin_idx;
    end
    if (finish && slot_free) begin
      hit         <= fin_hit;
      mac_result  <= fin_mac;
      entry_index <= fin_idx;
    end else if ((state == ST_HOLD) && slot_free) begin
      hit         <= res_hit;
      mac_result  <= res_mac;
      entry_index <= res_idx;
    end
  end

endmodule

// ----- rtl/arpc_checker.sv -----
// Port-level checker for arp_address_cache, attached by bind.
// Depends on arpc_pkg.
module arpc_checker
  import arpc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_stall,
  input logic             rsp_valid,
  input logic             rsp_stall,
  input logic             hit,
  input logic [MAC_W-1:0] mac_result,
  input logic [IDX_W-1:0] entry_index
);

  // one request in flight: the walk always stalls the next beat
  a_req_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted back to back");

  // a returned MAC only comes with a hit
  a_mac_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (mac_result != '0)) |-> hit)
    else $error("nonzero mac_result without hit");

  // reset leaves no response pending
  a_reset_clears_rsp: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  a_rsp_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      ($stable(hit) && $stable(mac_result) && $stable(entry_index)))
    else $error("response payload changed while stalled");

endmodule

bind arp_address_cache arpc_checker u_arpc_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for arp_address_cache: directed and random lookup/insert
// traffic, with a cycle-accurate-free shadow table predicting every response beat.
// Depends on arpc_pkg and the arp_address_cache RTL only.
module testbench;
  import arpc_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int POOL_SIZE = 24;   // a little larger than the table, so entries get evicted

  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac;
    logic [IDX_W-1:0] index;
  } cache_rsp_t;

  // ---------------------------------------------------------------------------
  // Clock and DUT
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  logic             operation;
  logic [IP_W-1:0]  ip_address;
  logic [MAC_W-1:0] mac_address;
  logic             rsp_valid;
  logic             rsp_stall;
  logic             hit;
  logic [MAC_W-1:0] mac_result;
  logic [IDX_W-1:0] entry_index;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  arp_address_cache #(.ENTRIES(ENTRIES)) dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .ip_address  (ip_address),
    .mac_address (mac_address),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .hit         (hit),
    .mac_result  (mac_result),
    .entry_index (entry_index)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the address table and the responses it predicts
  // ---------------------------------------------------------------------------
  logic [IP_W-1:0]  shadow_ip    [ENTRIES];
  logic [MAC_W-1:0] shadow_mac   [ENTRIES];
  bit               shadow_valid [ENTRIES];
  int unsigned      shadow_ptr;          // round-robin victim slot

  cache_rsp_t       expected_rsp_q [$];  // one entry per accepted request, in order
  cache_rsp_t       rsp_expected;

  logic [IP_W-1:0]  ip_pool [POOL_SIZE];

  // Run controls shared between the test tasks and the two side processes
  bit               idle_en = 1'b1;      // random gaps on both sides
  int               long_hold_cycles = 0;

  // Statistics for the closing summary, and the failure count
  int errors = 0;
  int rsp_checked = 0;
  int lookup_hits = 0, lookup_misses = 0;
  int new_entries = 0, refreshes = 0, evictions = 0;
  int req_stall_cycles = 0, long_holds = 0;

  // Resolve one request against the shadow table; updates the table on an insert.
  function automatic cache_rsp_t resolve_request(input logic op, input logic [IP_W-1:0] ip,
                                                 input logic [MAC_W-1:0] mac);
    cache_rsp_t  r;
    int          found;
    int          i;
    int unsigned slot;
    r     = '0;
    found = -1;
    // first valid match in index order; duplicates cannot form, since an
    // insert refreshes a matching entry instead of allocating a new one
    for (i = 0; i < ENTRIES; i++)
      if (found < 0 && shadow_valid[i] && shadow_ip[i] == ip) found = i;

    if (op == OP_LOOKUP) begin
      if (found >= 0) begin
        r.hit   = 1'b1;
        r.mac   = shadow_mac[found];
        r.index = found[IDX_W-1:0];
        lookup_hits++;
      end else begin
        lookup_misses++;            // all fields stay zero
      end
    end else if (found >= 0) begin
      // refresh in place; mac_result stays zero on inserts
      shadow_mac[found] = mac;
      r.hit   = 1'b1;
      r.index = found[IDX_W-1:0];
      refreshes++;
    end else begin
      // allocate at the pointer, evicting whatever sits there
      slot = shadow_ptr % ENTRIES;
      if (shadow_valid[slot]) evictions++;
      shadow_ip[slot]    = ip;
      shadow_mac[slot]   = mac;
      shadow_valid[slot] = 1'b1;
      shadow_ptr         = (slot + 1) % ENTRIES;
      r.index            = slot[IDX_W-1:0];
      new_entries++;
    end
    return r;
  endfunction

  // Mostly short idles, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one beat per call. Valid is left high after acceptance so the
  // next call can go back to back; the next call drops it only if it idles.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [IP_W-1:0] ip,
                              input logic [MAC_W-1:0] mac);
    int gap;
    gap = idle_en ? idle_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid   <= 1'b1;
    operation   <= op;
    ip_address  <= ip;
    mac_address <= mac;
    @(posedge clk);
    while (req_stall) begin
      req_stall_cycles++;
      @(posedge clk);
    end
    // accepted at this edge: predict now, in acceptance order
    expected_rsp_q.push_back(resolve_request(op, ip, mac));
  endtask

  // ---------------------------------------------------------------------------
  // Response side: stall pattern, driven at the falling edge. A long hold-off
  // requested by a test is counted out here, cycle by cycle.
  // ---------------------------------------------------------------------------
  initial begin : rsp_driver
    int hold_count;
    int len;
    rsp_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_cycles > 0) begin
        hold_count       = long_hold_cycles;
        long_hold_cycles = 0;
        long_holds++;
        rsp_stall <= 1'b1;
        while (hold_count > 0) begin
          @(negedge clk);
          hold_count--;
        end
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        len = idle_length() + 1;
        rsp_stall <= 1'b1;
        repeat (len) @(negedge clk);
      end else begin
        rsp_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Response checker: every accepted beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response beat hit=%b mac=%h index=%0d",
                 $time, hit, mac_result, entry_index);
      end else begin
        rsp_expected = expected_rsp_q.pop_front();
        rsp_checked++;
        if (hit !== rsp_expected.hit) begin
          errors++;
          $display("%0t: hit mismatch, expected %b actual %b",
                   $time, rsp_expected.hit, hit);
        end
        if (mac_result !== rsp_expected.mac) begin
          errors++;
          $display("%0t: mac_result mismatch, expected %h actual %h",
                   $time, rsp_expected.mac, mac_result);
        end
        if (entry_index !== rsp_expected.index) begin
          errors++;
          $display("%0t: entry_index mismatch, expected %0d actual %0d",
                   $time, rsp_expected.index, entry_index);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: lookups of the extreme keys miss with all-zero responses.
  task automatic test_empty_cache();
    send_request(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
  endtask

  // Extreme keys and MACs: new inserts, hits, refresh of an existing entry,
  // and a lookup whose MAC field must be ignored.
  task automatic test_insert_and_refresh();
    send_request(OP_INSERT, 32'h0000_0000, 48'h0000_0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_request(OP_LOOKUP, 32'h0000_0000, 48'h1234_5678_9ABC);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 48'h5A5A_0F0F_A5A5);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
  endtask

  // Fill the remaining slots and wrap the pointer: the oldest entry (key zero)
  // is evicted, and the top slot answers with index 15.
  task automatic test_wrap_eviction();
    int i;
    for (i = 0; i < ENTRIES - 1; i++)
      send_request(OP_INSERT, 32'h0A00_0001 + i, rand_mac());
    send_request(OP_LOOKUP, 32'h0000_0000, rand_mac());
    send_request(OP_LOOKUP, 32'h0A00_000E, rand_mac());
  endtask

  // Mostly lookups and inserts on a small key pool (hits, refreshes, evictions),
  // with some fully random keys that almost always miss.
  task automatic test_random_traffic(input int count);
    int                n;
    int                r;
    logic [IP_W-1:0]   key;
    for (n = 0; n < POOL_SIZE; n++) ip_pool[n] = $urandom;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8) ip_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;   // churn the pool
      key = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 45)      send_request(OP_INSERT, key, rand_mac());
      else if (r < 85) send_request(OP_LOOKUP, key, rand_mac());
      else if (r < 92) send_request(OP_INSERT, $urandom, rand_mac());
      else             send_request(OP_LOOKUP, $urandom, rand_mac());
    end
  endtask

  // No idling on either side: requests back to back, responses taken at once.
  task automatic test_back_to_back(input int count);
    idle_en = 1'b0;
    test_random_traffic(count);
    idle_en = 1'b1;
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // output register and the parked result fill and req_stall must rise.
  task automatic test_output_backpressure(input int count);
    idle_en          = 1'b0;
    long_hold_cycles = 300;
    test_random_traffic(count);
    idle_en = 1'b1;
  endtask

  // Release the request channel and wait for every prediction to be matched,
  // then a little longer to catch stray beats.
  task automatic wait_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int i;
    rst         = 1'b1;
    req_valid   = 1'b0;
    operation   = OP_LOOKUP;
    ip_address  = '0;
    mac_address = '0;
    for (i = 0; i < ENTRIES; i++) begin
      shadow_ip[i]    = '0;
      shadow_mac[i]   = '0;
      shadow_valid[i] = 1'b0;
    end
    shadow_ptr = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_cache();
    test_insert_and_refresh();
    test_wrap_eviction();
    test_random_traffic(300);
    test_back_to_back(150);
    test_output_backpressure(40);
    test_random_traffic(260);
    wait_drained();

    $display("Covered %0d responses: %0d lookup hits, %0d lookup misses, %0d new entries,",
             rsp_checked, lookup_hits, lookup_misses, new_entries);
    $display("%0d refreshes, %0d evictions, %0d request stall cycles, %0d long hold-offs.",
             refreshes, evictions, req_stall_cycles, long_holds);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d responses still outstanding", expected_rsp_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/arpc_pkg.sv
rtl/arp_address_cache.sv
rtl/arpc_checker.sv
tb/testbench.sv
